FILE: hw/rtl/prba_pkg.sv
// prba_pkg: shared types and fixed constants of the point rotation pipeline.
// Holds the beat payload structs, the sideband carried down the pipe and the
// Q31 constants of the angle fold and the sine/cosine series.
package prba_pkg;

  localparam int unsigned CoordWidth  = 16;
  localparam int unsigned AngleWidth  = 16;
  localparam int unsigned SeriesSteps = 10;
  // largest series divisor is 20 * 21 = 420
  localparam int unsigned DivWidth    = 9;

  localparam logic [31:0] OneQ31    = 32'h8000_0000;
  localparam logic [31:0] HalfPiQ31 = 32'hC90F_DAA2;
  localparam logic [31:0] FlushQ31  = 32'd21474;

  typedef enum logic [1:0] {
    QuadFirst  = 2'd0,
    QuadSecond = 2'd1,
    QuadThird  = 2'd2,
    QuadFourth = 2'd3
  } prba_quad_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x_in;
    logic signed [CoordWidth-1:0] y_in;
    logic [AngleWidth-1:0]        angle_turn;
  } prba_in_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x_out;
    logic signed [CoordWidth-1:0] y_out;
    logic                         saturated;
  } prba_out_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] x;
    logic signed [CoordWidth-1:0] y;
    prba_quad_e                   quad;
    logic                         swap;
  } prba_side_t;

  // running state of the sine and cosine series, all magnitudes in Q31
  typedef struct packed {
    prba_side_t  side;
    logic [30:0] x2;
    logic [31:0] ts;
    logic [31:0] tc;
    logic [31:0] sv;
    logic [31:0] cv;
  } prba_ser_t;

endpackage

FILE: hw/rtl/prba_front.sv
// prba_front: angle fold into the first octant, angle to radians, theta squared.
// Three register stages; feeds the first series step. Depends on prba_pkg.
module prba_front import prba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  prba_in_t  data_i,
  output logic      valid_o,
  output prba_ser_t data_o
);

  localparam int unsigned FracPad = 33 - AngleWidth;

  logic [2:0]  valid_q;
  prba_side_t  side1_q, side2_q;
  logic [30:0] fold_q, th_q;
  prba_ser_t   ser_q;

  logic [31:0] frac;
  logic        swap;
  logic [31:0] fold_full;
  logic [62:0] th_prod;
  logic [61:0] sq_prod;

  // quarter-turn fraction scaled to Q31, folded about one eighth turn
  assign frac      = {1'b0, data_i.angle_turn[AngleWidth-3:0], {FracPad{1'b0}}};
  assign swap      = frac > {2'b01, 30'd0};
  assign fold_full = swap ? (OneQ31 - frac) : frac;
  assign th_prod   = 63'(fold_q) * 63'(HalfPiQ31);
  assign sq_prod   = 62'(th_q) * 62'(th_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q.x    <= data_i.x_in;
      side1_q.y    <= data_i.y_in;
      side1_q.quad <= prba_quad_e'(data_i.angle_turn[AngleWidth-1 -: 2]);
      side1_q.swap <= swap;
      fold_q       <= fold_full[30:0];
      side2_q      <= side1_q;
      th_q         <= th_prod[61:31];
      ser_q.side   <= side2_q;
      ser_q.x2     <= sq_prod[61:31];
      ser_q.ts     <= {1'b0, th_q};
      ser_q.tc     <= OneQ31;
      ser_q.sv     <= {1'b0, th_q};
      ser_q.cv     <= OneQ31;
    end
  end

  assign valid_o = valid_q[2];
  assign data_o  = ser_q;

endmodule

FILE: hw/rtl/prba_step.sv
// prba_step: one term update of the sine and cosine series, four stages:
// term times theta^2, reciprocal divide, quotient fix-up, accumulate.
// Depends on prba_pkg.
module prba_step import prba_pkg::*; #(
  parameter int unsigned STEP = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  prba_ser_t data_i,
  output logic      valid_o,
  output prba_ser_t data_o
);

  localparam int unsigned SinDiv = 2 * STEP * (2 * STEP + 1);
  localparam int unsigned CosDiv = (2 * STEP - 1) * (2 * STEP);
  localparam logic [32:0] SinRecip = 33'((65'd1 << 33) / SinDiv);
  localparam logic [32:0] CosRecip = 33'((65'd1 << 33) / CosDiv);
  localparam logic [DivWidth-1:0] SinDivW = DivWidth'(SinDiv);
  localparam logic [DivWidth-1:0] CosDivW = DivWidth'(CosDiv);
  localparam bit Subtract = (STEP % 2) == 1;

  logic [3:0]  valid_q;
  prba_ser_t   ser_a_q, ser_b_q, ser_c_q, ser_d_q;
  logic [30:0] vs_a_q, vc_a_q, vs_b_q, vc_b_q;
  logic [30:0] qs0_b_q, qc0_b_q, qs_c_q, qc_c_q;

  logic [62:0] ps, pc;
  logic [63:0] rs_prod, rc_prod;
  logic [39:0] ms, mc;
  logic [30:0] rems, remc;
  logic [30:0] qs, qc;

  assign ps = 63'(data_i.ts) * 63'(data_i.x2);
  assign pc = 63'(data_i.tc) * 63'(data_i.x2);

  // floor(v * floor(2^33 / d) / 2^33) is the quotient or one less
  assign rs_prod = 64'(vs_a_q) * 64'(SinRecip);
  assign rc_prod = 64'(vc_a_q) * 64'(CosRecip);

  assign ms   = 40'(qs0_b_q) * 40'(SinDivW);
  assign mc   = 40'(qc0_b_q) * 40'(CosDivW);
  assign rems = vs_b_q - ms[30:0];
  assign remc = vc_b_q - mc[30:0];
  assign qs   = qs0_b_q + 31'(rems >= 31'(SinDivW));
  assign qc   = qc0_b_q + 31'(remc >= 31'(CosDivW));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ser_a_q <= data_i;
      vs_a_q  <= ps[61:31];
      vc_a_q  <= pc[61:31];
      ser_b_q <= ser_a_q;
      vs_b_q  <= vs_a_q;
      vc_b_q  <= vc_a_q;
      qs0_b_q <= rs_prod[63:33];
      qc0_b_q <= rc_prod[63:33];
      ser_c_q <= ser_b_q;
      qs_c_q  <= qs;
      qc_c_q  <= qc;
      ser_d_q.side <= ser_c_q.side;
      ser_d_q.x2   <= ser_c_q.x2;
      ser_d_q.ts   <= {1'b0, qs_c_q};
      ser_d_q.tc   <= {1'b0, qc_c_q};
      if (Subtract) begin
        ser_d_q.sv <= ser_c_q.sv - {1'b0, qs_c_q};
        ser_d_q.cv <= ser_c_q.cv - {1'b0, qc_c_q};
      end else begin
        ser_d_q.sv <= ser_c_q.sv + {1'b0, qs_c_q};
        ser_d_q.cv <= ser_c_q.cv + {1'b0, qc_c_q};
      end
    end
  end

  assign valid_o = valid_q[3];
  assign data_o  = ser_d_q;

endmodule

FILE: hw/rtl/prba_back.sv
// prba_back: quadrant mapping and trig rounding, the four products, the two
// sums, half-away-from-zero rounding and saturation. Five register stages.
// Depends on prba_pkg.
module prba_back import prba_pkg::*; #(
  parameter int unsigned TRIG_FRACTION_BITS = 17
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  prba_ser_t data_i,
  output logic      valid_o,
  output prba_out_t data_o
);

  localparam int unsigned TW = TRIG_FRACTION_BITS + 2;
  localparam int unsigned PW = CoordWidth + TW;
  localparam int unsigned SW = PW + 1;
  localparam int unsigned QW = CoordWidth + 2;
  localparam logic [32:0]    TrigHalf = 33'(1) << (30 - TRIG_FRACTION_BITS);
  localparam logic [SW-1:0]  SumHalf  = SW'(1) << (TRIG_FRACTION_BITS - 1);
  localparam logic [QW-1:0]  QLim     = QW'(1) << (CoordWidth - 1);

  function automatic logic signed [TW-1:0] trig_round(logic [31:0] mag, logic neg);
    logic [32:0] r;
    r = (33'(mag) + TrigHalf) >> (31 - TRIG_FRACTION_BITS);
    if (mag <= FlushQ31) begin
      return '0;
    end
    return neg ? -TW'(r) : TW'(r);
  endfunction

  // sign in the top bit, rounded magnitude below it
  function automatic logic [QW:0] round_half(logic signed [SW-1:0] s);
    logic [SW-1:0] m;
    logic [SW-1:0] q;
    m = s[SW-1] ? SW'(-s) : SW'(s);
    q = (m + SumHalf) >> TRIG_FRACTION_BITS;
    return {s[SW-1], q[QW-1:0]};
  endfunction

  // clipped flag on top, coordinate below it
  function automatic logic [CoordWidth:0] to_coord(logic [QW:0] r);
    logic [QW-1:0] q;
    logic          sat;
    q   = r[QW-1:0];
    sat = 1'b0;
    if (r[QW]) begin
      if (q > QLim) begin
        q   = QLim;
        sat = 1'b1;
      end
      q = -q;
    end else if (q > QLim - QW'(1)) begin
      q   = QLim - QW'(1);
      sat = 1'b1;
    end
    return {sat, q[CoordWidth-1:0]};
  endfunction

  logic [4:0] valid_q;

  logic signed [CoordWidth-1:0] x1_q, y1_q;
  logic signed [TW-1:0]         sn_q, cs_q;
  logic signed [PW-1:0]         pxc_q, pys_q, pxs_q, pyc_q;
  logic signed [SW-1:0]         sum_x_q, sum_y_q;
  logic [QW:0]                  rnd_x_q, rnd_y_q;
  prba_out_t                    out_q;

  logic [31:0] sm0, cm0, sm, cm;
  logic        sneg, cneg;
  logic [CoordWidth:0] cx, cy;

  always_comb begin
    sm0 = data_i.side.swap ? data_i.cv : data_i.sv;
    cm0 = data_i.side.swap ? data_i.sv : data_i.cv;
    unique case (data_i.side.quad)
      QuadFirst: begin
        sm = sm0; cm = cm0; sneg = 1'b0; cneg = 1'b0;
      end
      QuadSecond: begin
        sm = cm0; cm = sm0; sneg = 1'b0; cneg = 1'b1;
      end
      QuadThird: begin
        sm = sm0; cm = cm0; sneg = 1'b1; cneg = 1'b1;
      end
      QuadFourth: begin
        sm = cm0; cm = sm0; sneg = 1'b1; cneg = 1'b0;
      end
    endcase
  end

  assign cx = to_coord(rnd_x_q);
  assign cy = to_coord(rnd_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= data_i.side.x;
      y1_q    <= data_i.side.y;
      sn_q    <= trig_round(sm, sneg);
      cs_q    <= trig_round(cm, cneg);
      pxc_q   <= PW'(x1_q) * PW'(cs_q);
      pys_q   <= PW'(y1_q) * PW'(sn_q);
      pxs_q   <= PW'(x1_q) * PW'(sn_q);
      pyc_q   <= PW'(y1_q) * PW'(cs_q);
      sum_x_q <= SW'(pxc_q) - SW'(pys_q);
      sum_y_q <= SW'(pxs_q) + SW'(pyc_q);
      rnd_x_q <= round_half(sum_x_q);
      rnd_y_q <= round_half(sum_y_q);
      out_q.x_out     <= cx[CoordWidth-1:0];
      out_q.y_out     <= cy[CoordWidth-1:0];
      out_q.saturated <= cx[CoordWidth] | cy[CoordWidth];
    end
  end

  assign valid_o = valid_q[4];
  assign data_o  = out_q;

endmodule

FILE: hw/rtl/point_rotate_by_angle_top.sv
// point_rotate_by_angle_top: rotates an integer point about the origin by an
// angle given as a binary fraction of a full turn.
// Depends on prba_pkg, prba_front, prba_step and prba_back.
//
// Input channel in_valid_i / in_ready_o carries x_in, y_in and angle_turn;
// output channel out_valid_o / out_ready_i carries x_out, y_out and the
// saturated flag. Every input beat gives exactly one output beat, in order.
// Sine and cosine come from a fixed-point series of ten term updates, one update per
// four pipeline stages, followed by the rotation products and rounding.
// The path holds 49 register stages (3 front, 40 series, 5 back, 1 output).
// It accepts one beat per cycle while not frozen by a stall, set by the fully
// pipelined multipliers; every stage advances together.
// Reset clears all valid bits; the pipe comes up empty and ready.
// When the receiver stalls, one beat goes into a skid register and the whole
// pipe then freezes with in_ready_o low until the skid beat moves on; nothing
// is dropped or repeated.
module point_rotate_by_angle_top import prba_pkg::*; #(
  parameter int unsigned TRIG_FRACTION_BITS = 17
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  prba_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output prba_out_t out_data_o
);

  localparam logic signed [CoordWidth-1:0] CoordMax = {1'b0, {(CoordWidth - 1){1'b1}}};
  localparam logic signed [CoordWidth-1:0] CoordMin = {1'b1, {(CoordWidth - 1){1'b0}}};

  logic                 pipe_en;
  logic [SeriesSteps:0] ser_valid;
  prba_ser_t            ser [SeriesSteps+1];
  logic                 pipe_valid;
  prba_out_t            pipe_data;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  prba_out_t out_data_q, skid_data_q;
  logic      out_free;

  assign pipe_en    = !skid_valid_q;
  assign in_ready_o = pipe_en;

  prba_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (ser_valid[0]),
    .data_o  (ser[0])
  );

  for (genvar g = 0; g < SeriesSteps; g++) begin : g_step
    prba_step #(
      .STEP (g + 1)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (ser_valid[g]),
      .data_i  (ser[g]),
      .valid_o (ser_valid[g+1]),
      .data_o  (ser[g+1])
    );
  end

  prba_back #(
    .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (ser_valid[SeriesSteps]),
    .data_i  (ser[SeriesSteps]),
    .valid_o (pipe_valid),
    .data_o  (pipe_data)
  );

  // output register with one skid entry behind it
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || (pipe_en && pipe_valid);
      skid_valid_d = 1'b0;
    end else if (pipe_en && pipe_valid) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : pipe_data;
    end else if (pipe_en && pipe_valid) begin
      skid_data_q <= pipe_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register is empty");

  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid entry filled without an output stall");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved to output when taken");

  a_sat_at_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.saturated) |->
      (out_data_q.x_out == CoordMax || out_data_q.x_out == CoordMin ||
       out_data_q.y_out == CoordMax || out_data_q.y_out == CoordMin))
    else $error("saturated flag set with no coordinate at a bound");

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for point_rotate_by_angle_top, rotation of a point by a turn fraction.
// Depends on prba_pkg and the rtl below it; typed rows or a fixed-point sine/cosine predictor give
// the expected beats, driven by a directed table and then random points with random stalls.
`timescale 1ns / 100ps

module tb;
  import prba_pkg::*;

  localparam int TrigFrac     = 17;
  localparam int RandPoints   = 1050;
  localparam int RxHoldCycles = 300;
  localparam int DrainCycles  = 60;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    prba_in_t  stim;
    logic      typed;
    prba_out_t want;
  } vec_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  prba_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  prba_out_t out_data;

  prba_out_t rotated_q[$];
  vec_row_t  dir_tab[$];
  int        err_cnt = 0;
  int        points_sent = 0;
  int        results_seen = 0;
  int        clipped_seen = 0;
  bit        quiet = 1'b0;
  bit        hold_rx = 1'b0;

  always #5 clk = ~clk;

  point_rotate_by_angle_top #(
    .TRIG_FRACTION_BITS(TrigFrac)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // flush tiny magnitudes, round half up to the trig fraction, then apply sign
  function automatic longint round_trig(logic [63:0] mag, bit neg);
    logic [63:0] r;
    if (mag <= 64'(FlushQ31)) return 0;
    r = (mag + (64'd1 << (30 - TrigFrac))) >> (31 - TrigFrac);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // top bit is the clip flag, the rest is the rounded coordinate
  function automatic logic [CoordWidth:0] clip_coord(longint sum);
    logic [63:0] mag, q, lim;
    bit          clip;
    clip = 1'b0;
    mag = (sum < 0) ? 64'(-sum) : 64'(sum);
    q = (mag + (64'd1 << (TrigFrac - 1))) >> TrigFrac;
    lim = 64'd1 << (CoordWidth - 1);
    if (sum < 0) begin
      if (q > lim) begin
        q = lim;
        clip = 1'b1;
      end
      q = 64'd0 - q;
    end else if (q > lim - 1) begin
      q = lim - 1;
      clip = 1'b1;
    end
    return {clip, q[CoordWidth-1:0]};
  endfunction

  function automatic prba_out_t rotate_point(prba_in_t p);
    logic [63:0]         frac, th, x2, ts, tc, sv, cv, smag, cmag, tmp;
    prba_quad_e          quad;
    bit                  fold, sneg, cneg;
    longint              sn, cs;
    logic [CoordWidth:0] rx, ry;
    prba_out_t           r;
    quad = prba_quad_e'(p.angle_turn[AngleWidth-1 -: 2]);
    frac = 64'(p.angle_turn[AngleWidth-3:0]) << (33 - AngleWidth);
    fold = frac > (64'(OneQ31) >> 1);
    if (fold) frac = 64'(OneQ31) - frac;
    th = (frac * 64'(HalfPiQ31)) >> 31;
    x2 = (th * th) >> 31;
    ts = th;
    tc = 64'(OneQ31);
    sv = th;
    cv = 64'(OneQ31);
    for (int k = 1; k <= SeriesSteps; k++) begin
      ts = ((ts * x2) >> 31) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 31) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sv = sv - ts;
        cv = cv - tc;
      end else begin
        sv = sv + ts;
        cv = cv + tc;
      end
    end
    smag = fold ? cv : sv;
    cmag = fold ? sv : cv;
    case (quad)
      QuadFirst: begin
        sneg = 1'b0;
        cneg = 1'b0;
      end
      QuadSecond: begin
        tmp = smag; smag = cmag; cmag = tmp;
        sneg = 1'b0;
        cneg = 1'b1;
      end
      QuadThird: begin
        sneg = 1'b1;
        cneg = 1'b1;
      end
      default: begin
        tmp = smag; smag = cmag; cmag = tmp;
        sneg = 1'b1;
        cneg = 1'b0;
      end
    endcase
    sn = round_trig(smag, sneg);
    cs = round_trig(cmag, cneg);
    rx = clip_coord(longint'(p.x_in) * cs - longint'(p.y_in) * sn);
    ry = clip_coord(longint'(p.x_in) * sn + longint'(p.y_in) * cs);
    r.x_out = rx[CoordWidth-1:0];
    r.y_out = ry[CoordWidth-1:0];
    r.saturated = rx[CoordWidth] | ry[CoordWidth];
    return r;
  endfunction

  function automatic vec_row_t mk_row(int x, int y, int a, bit typed, int xo, int yo, bit sat);
    vec_row_t v;
    v.stim.x_in = coord_t'(x);
    v.stim.y_in = coord_t'(y);
    v.stim.angle_turn = AngleWidth'(a);
    v.typed = typed;
    v.want.x_out = coord_t'(xo);
    v.want.y_out = coord_t'(yo);
    v.want.saturated = sat;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      7, 8:    return coord_t'($urandom_range(0, 200) - 100);
      9: begin
        case ($urandom_range(0, 3))
          0:       return coord_t'(-32768);
          1:       return coord_t'(32767);
          2:       return coord_t'(-32767);
          default: return coord_t'(0);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic logic [AngleWidth-1:0] pick_angle();
    // near octant boundaries, where the fold and quadrant logic switch over
    if ($urandom_range(0, 9) >= 7)
      return AngleWidth'($urandom_range(0, 7) * (1 << (AngleWidth - 3))
                         + $urandom_range(0, 4) - 2);
    return AngleWidth'($urandom);
  endfunction

  task automatic send_point(input prba_in_t p, input bit typed, input prba_out_t want);
    in_valid <= 1'b1;
    in_data  <= p;
    rotated_q = {rotated_q, (typed ? want : rotate_point(p))};
    do @(posedge clk); while (!in_ready);
    points_sent++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // result beats against the oldest expected rotation
  always @(posedge clk) begin : chk
    prba_out_t want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (out_data.saturated) clipped_seen++;
      if (rotated_q.size() == 0) begin
        note_error($sformatf("unexpected beat x=%0d y=%0d sat=%0b",
                             out_data.x_out, out_data.y_out, out_data.saturated));
      end else begin
        want = rotated_q.pop_front();
        if (out_data.x_out !== want.x_out || out_data.y_out !== want.y_out ||
            out_data.saturated !== want.saturated)
          note_error($sformatf("exp x=%0d y=%0d sat=%0b got x=%0d y=%0d sat=%0b",
                               want.x_out, want.y_out, want.saturated,
                               out_data.x_out, out_data.y_out, out_data.saturated));
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin : rx
    int stall;
    stall = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        out_ready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk);
        hold_rx = 1'b0;
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          stall--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  initial begin : main
    prba_in_t pt;
    // typed rows: zero angle, quarter turns, exact zero, clipping at the extremes
    dir_tab = {dir_tab, mk_row(     0,      0, 'h0000, 1,      0,      0, 0)};
    dir_tab = {dir_tab, mk_row(   100,   -200, 'h0000, 1,    100,   -200, 0)};
    dir_tab = {dir_tab, mk_row( 32767, -32768, 'h0000, 1,  32767, -32768, 0)};
    dir_tab = {dir_tab, mk_row(  1000,   2000, 'h4000, 1,  -2000,   1000, 0)};
    dir_tab = {dir_tab, mk_row(-32768, -32768, 'h4000, 1,  32767, -32768, 1)};
    dir_tab = {dir_tab, mk_row(-32768,      5, 'h8000, 1,  32767,     -5, 1)};
    dir_tab = {dir_tab, mk_row( 32767, -32767, 'h8000, 1, -32767,  32767, 0)};
    dir_tab = {dir_tab, mk_row(   300,     -7, 'hC000, 1,     -7,   -300, 0)};
    dir_tab = {dir_tab, mk_row( 32767,  32767, 'hC000, 1,  32767, -32767, 0)};
    dir_tab = {dir_tab, mk_row(     0,      0, 'hFFFF, 1,      0,      0, 0)};
    // predicted rows: fold boundary, 45 degrees, smallest angle steps
    dir_tab = {dir_tab, mk_row(  1234,   1234, 'h2000, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row( 32767,  32767, 'h2000, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(-32768, -32768, 'h2000, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(-32768,  32767, 'h6000, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(     1,      0, 'h0001, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row( 32767,      0, 'h0001, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(     0, -32768, 'hFFFF, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row( 12345, -23456, 'h1FFF, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row( 12345, -23456, 'h2001, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(    -1,      1, 'h3FFF, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(    -5,      3, 'h4001, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row( 32767, -32768, 'hA000, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(     7,      7, 'h7FFF, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(-20000,  25000, 'hBFFF, 0, 0, 0, 0)};
    dir_tab = {dir_tab, mk_row(     3,     -3, 'hE000, 0, 0, 0, 0)};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_point(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].want);
      idle_sender();
    end

    for (int n = 0; n < RandPoints; n++) begin
      quiet = (n >= 700 && n < 800);
      // long receiver hold-off while beats keep coming, so the pipe backs up
      if (n == 300) hold_rx = 1'b1;
      pt.x_in = pick_coord();
      pt.y_in = pick_coord();
      pt.angle_turn = pick_angle();
      send_point(pt, 1'b0, '0);
      if (n == 600) begin
        in_valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
      end else begin
        idle_sender();
      end
    end
    in_valid <= 1'b0;
    quiet = 1'b0;

    while (rotated_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d points (%0d from the table) over all quadrants and octant edges",
             points_sent, dir_tab.size());
    $display("checked %0d rotated beats, %0d clipped, %0d mismatches",
             results_seen, clipped_seen, err_cnt);
    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/prba_pkg.sv
hw/rtl/prba_front.sv
hw/rtl/prba_step.sv
hw/rtl/prba_back.sv
hw/rtl/point_rotate_by_angle_top.sv
dv/tb.sv
